FILE: rtl/temperature_seven_segment_display_assert.svh
// Assertion macros for the checker file of the temperature display.
// Every macro samples on the rising edge of clk and is muted while rst is high.
`ifndef TEMPERATURE_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH
`define TEMPERATURE_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH

// Checks a same-cycle property.
`define TSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next cycle.
`define TSSD_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

FILE: rtl/tssd_pkg.sv
// Package for the temperature seven-segment display.
// It holds the transaction types, the digit codes and the segment decode.
// It has no dependencies.
package tssd_pkg;

  localparam int DIGIT_COUNT = 6;

  // Request kinds.
  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Digit codes. The values 0 to 9 are plain decimal digits.
  localparam logic [3:0] CODE_BLANK  = 4'h0a;
  localparam logic [3:0] CODE_C      = 4'h0b;
  localparam logic [3:0] CODE_DEGREE = 4'h0c;
  localparam logic [3:0] CODE_MINUS  = 4'h0d;

  // Scan constants.
  localparam logic [2:0] POS_BLANK_SLOT = 3'd6;
  localparam logic [2:0] POS_DOT        = 3'd3;
  localparam logic [7:0] PATTERN_FIRST  = 8'h7f;
  localparam logic [7:0] PORT_DARK      = 8'hff;

  typedef logic [3:0] code_t;
  typedef code_t [DIGIT_COUNT-1:0] codes_t;

  typedef struct packed {
    logic        req_type;
    logic        sensor_absent;
    logic [15:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic [7:0] segment_byte;
    logic [7:0] digit_select;
  } out_t;

  // Control from the pipeline to the scan unit.
  typedef struct packed {
    logic fire;
    logic tick;
    logic absent;
  } step_t;

  // Active-low segment pattern for a digit code. Unused codes show blank.
  function automatic logic [7:0] seg_decode(input code_t code);
    logic [7:0] seg;
    case (code)
      4'd0:        seg = 8'hc0;
      4'd1:        seg = 8'hf9;
      4'd2:        seg = 8'ha4;
      4'd3:        seg = 8'hb0;
      4'd4:        seg = 8'h99;
      4'd5:        seg = 8'h92;
      4'd6:        seg = 8'h82;
      4'd7:        seg = 8'hf8;
      4'd8:        seg = 8'h80;
      4'd9:        seg = 8'h90;
      CODE_C:      seg = 8'hc6;
      CODE_DEGREE: seg = 8'h9c;
      CODE_MINUS:  seg = 8'hbf;
      default:     seg = 8'hff;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/temperature_seven_segment_display.sv
// Temperature seven-segment display driver, top level.
// Path: a transaction accepted into the input register moves on to the port registers,
// which form the result register, when it advances; a stalled output holds it there.
// Throughput: one transaction per cycle unless stalled; the conversion is combinational.
// Reset (rst, synchronous): pipeline empty, sensor present, codes zero, ports 0xff.
module temperature_seven_segment_display import tssd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic   a_valid;
  in_t    a_data;
  logic   advance;
  logic   accept;
  step_t  step;
  codes_t new_codes;
  logic [7:0] segment_port;
  logic [7:0] select_port;

  // Move the held transaction on whenever the result register is free or being taken.
  assign advance  = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_data <= in_data;
    end
  end

  // Result valid follows the port registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign step.fire   = advance;
  assign step.tick   = a_data.req_type;
  assign step.absent = a_data.sensor_absent;

  tssd_convert u_convert (
    .raw_reading (a_data.raw_reading),
    .codes       (new_codes)
  );

  tssd_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .new_codes    (new_codes),
    .segment_port (segment_port),
    .select_port  (select_port)
  );

  // The port registers change only on advance, so a stalled result holds.
  assign out_data.segment_byte = segment_port;
  assign out_data.digit_select = select_port;

endmodule

FILE: rtl/tssd_convert.sv
// Converts a two's complement reading in sixteenths of a degree into six digit codes.
// Depends on tssd_pkg for the code values and the codes_t type.
module tssd_convert import tssd_pkg::*; (
  input  logic [15:0] raw_reading,
  output codes_t      codes
);

  logic        negative;
  logic [15:0] mag;
  logic [7:0]  whole;
  logic [1:0]  hundreds;
  logic [7:0]  hund_sub;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [7:0]  frac_x10;
  logic [3:0]  tenths;

  // Magnitude by plain 16-bit negation of negative readings.
  assign negative = raw_reading[15];
  assign mag      = negative ? 16'(16'd0 - raw_reading) : raw_reading;
  assign whole    = mag[11:4];

  // Hundreds by comparison, since the integer part stays below 256.
  always_comb begin
    if (whole >= 8'd200) begin
      hundreds = 2'd2;
      hund_sub = 8'd200;
    end else if (whole >= 8'd100) begin
      hundreds = 2'd1;
      hund_sub = 8'd100;
    end else begin
      hundreds = 2'd0;
      hund_sub = 8'd0;
    end
  end

  // Tens by multiplying with 205/2048, exact for values below 100.
  assign rem       = 7'(whole - hund_sub);
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign units     = 4'(rem - 7'(tens) * 7'd10);

  // Tenths are the fraction times ten, divided by sixteen.
  assign frac_x10 = 8'(mag[3:0]) * 8'd10;
  assign tenths   = frac_x10[7:4];

  // Assemble codes with leading-zero blanking and the minus sign.
  always_comb begin
    codes[0] = CODE_C;
    codes[1] = CODE_DEGREE;
    codes[2] = tenths;
    codes[3] = units;
    codes[4] = tens;
    codes[5] = code_t'(hundreds);
    if (hundreds == 2'd0) begin
      codes[5] = CODE_BLANK;
      if (tens == 4'd0) begin
        codes[4] = CODE_BLANK;
      end
    end
    if (negative) begin
      codes[5] = CODE_MINUS;
    end
  end

endmodule

FILE: rtl/tssd_scan.sv
// Display state and multiplexed scan: stored digit codes, scan position and port registers.
// Depends on tssd_pkg for step_t, codes_t and the segment decode.
module tssd_scan import tssd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  step_t      step,
  input  codes_t     new_codes,
  output logic [7:0] segment_port,
  output logic [7:0] select_port
);

  logic       sensor_missing;
  codes_t     digit_codes;
  logic [2:0] scan_position;
  logic [7:0] select_pattern;
  logic [7:0] cur_seg;

  // Segment pattern of the digit under the scan, with the decimal point at the units digit.
  always_comb begin
    case (scan_position)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: cur_seg = seg_decode(digit_codes[scan_position]);
      default:                            cur_seg = PORT_DARK;
    endcase
    if (scan_position == POS_DOT) begin
      cur_seg[7] = 1'b0;
    end
  end

  // State update for each transaction that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_missing <= 1'b0;
      digit_codes    <= '0;
      scan_position  <= '0;
      select_pattern <= PATTERN_FIRST;
      segment_port   <= PORT_DARK;
      select_port    <= PORT_DARK;
    end else if (step.fire) begin
      if (step.tick == REQ_REPORT) begin
        sensor_missing <= step.absent;
        if (!step.absent) begin
          digit_codes <= new_codes;
        end
      end else if (sensor_missing) begin
        segment_port <= PORT_DARK;
        select_port  <= PORT_DARK;
      end else if (scan_position >= POS_BLANK_SLOT) begin
        scan_position  <= '0;
        select_pattern <= PATTERN_FIRST;
        select_port    <= PORT_DARK;
      end else begin
        segment_port   <= cur_seg;
        select_port    <= select_pattern;
        select_pattern <= {1'b1, select_pattern[7:1]};
        scan_position  <= scan_position + 3'd1;
      end
    end
  end

endmodule

FILE: rtl/tssd_checker.sv
// Port-level checks for the temperature display, bound to the top level.
// Depends on tssd_pkg and the assertion macro header.
`include "temperature_seven_segment_display_assert.svh"

module tssd_checker import tssd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result stays valid and unchanged.
  `TSSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // The input side only stalls while the result side is full and stalled.
  `TSSD_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without cause")

  // At most one digit is enabled at a time.
  `TSSD_ASSERT(a_one_digit, (out_valid && out_data.digit_select != PORT_DARK) |-> ($countones(~out_data.digit_select) == 1), "several digits enabled")

  // The decimal point is lit exactly on the units digit.
  `TSSD_ASSERT(a_dot_place, (out_valid && out_data.digit_select != PORT_DARK) |-> (out_data.segment_byte[7] == (out_data.digit_select != 8'hef)), "decimal point misplaced")

endmodule

bind temperature_seven_segment_display tssd_checker u_tssd_checker (.*);
